// ----- src/mcbmo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcbmo_pkg
// Shared types and constants of the batch median odometer.
// ----------------------------------------------------------------------------
package mcbmo_pkg;

  localparam int NumChan  = 5;
  localparam int IdW      = 8;
  localparam int ValW     = 8;
  localparam int SampW    = 9;
  localparam int DistW    = 20;
  localparam int KmW      = 32;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 20;

  localparam logic [DistW-1:0] AccMax = {DistW{1'b1}};

  typedef logic signed [SampW-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ID_US_CENTER     = 8'd0,
    REG_ID_US_SIDE       = 8'd1,
    REG_ID_IR_SIDE_FRONT = 8'd2,
    REG_ID_IR_SIDE_BACK  = 8'd3,
    REG_ID_IR_BACK       = 8'd4,
    REG_ID_ENCODER       = 8'd5,
    REG_KM_THRESHOLD     = 8'd6
  } reg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic load_out; // capture result into output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_start; // current input item is a frame start
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/mcbmo_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcbmo_in_if / mcbmo_out_if / mcbmo_cfg_if
// Valid/ready channels of the batch median odometer.
// ----------------------------------------------------------------------------
interface mcbmo_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [mcbmo_pkg::IdW-1:0]  sensor_id;
  logic [mcbmo_pkg::ValW-1:0] reading;
  modport source (output valid, kind, sensor_id, reading, input ready);
  modport sink   (input valid, kind, sensor_id, reading, output ready);
endinterface

interface mcbmo_out_if;
  logic                        valid;
  logic                        ready;
  mcbmo_pkg::sample_t          median_us_center;
  mcbmo_pkg::sample_t          median_us_side;
  mcbmo_pkg::sample_t          median_ir_side_front;
  mcbmo_pkg::sample_t          median_ir_side_back;
  mcbmo_pkg::sample_t          median_ir_back;
  logic [mcbmo_pkg::DistW-1:0] distance_in_km;
  logic [mcbmo_pkg::KmW-1:0]   km_count;
  logic                        unknown_id;
  logic                        dropped_full;
  modport source (output valid, median_us_center, median_us_side, median_ir_side_front,
                  median_ir_side_back, median_ir_back, distance_in_km, km_count,
                  unknown_id, dropped_full, input ready);
  modport sink   (input valid, median_us_center, median_us_side, median_ir_side_front,
                  median_ir_side_back, median_ir_back, distance_in_km, km_count,
                  unknown_id, dropped_full, output ready);
endinterface

interface mcbmo_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mcbmo_pkg::CfgIdxW-1:0]  index;
  logic [mcbmo_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/mcbmo_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcbmo_ctrl
// Sequencer: accept an item, then hand its medians to the output register.
// ----------------------------------------------------------------------------
module mcbmo_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire mcbmo_pkg::dp_status_t status_i,
  output mcbmo_pkg::dp_cmd_t         cmd_o
);
  import mcbmo_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MED
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.accept   = in_valid_i && in_ready_o;
  assign cmd_o.load_out = (state_q == ST_MED) && out_free;

  // next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && !status_i.frame_start) state_d = ST_MED;
      end
      ST_MED: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // checks
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> state_q == ST_IDLE) else $error("accept outside idle");
  a_item_med: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !status_i.frame_start) |=> state_q == ST_MED)
    else $error("reading did not reach median step");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q) else $error("load without valid");
  a_frame_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.frame_start) |=> state_q == ST_IDLE)
    else $error("frame start produced work");

endmodule
`default_nettype wire

// ----- src/mcbmo_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcbmo_datapath
// Config registers, sorted insert cells per channel, odometer, result register.
// ----------------------------------------------------------------------------
module mcbmo_datapath #(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mcbmo_pkg::dp_cmd_t           cmd_i,
  output mcbmo_pkg::dp_status_t             status_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [mcbmo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mcbmo_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         kind_i,
  input  wire logic [mcbmo_pkg::IdW-1:0]    sensor_id_i,
  input  wire logic [mcbmo_pkg::ValW-1:0]   reading_i,
  output mcbmo_pkg::sample_t                med_o [mcbmo_pkg::NumChan],
  output logic [mcbmo_pkg::DistW-1:0]       dist_o,
  output logic [mcbmo_pkg::KmW-1:0]         km_o,
  output logic                              unknown_o,
  output logic                              dropped_o
);
  import mcbmo_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] Full = CW'(LIST_DEPTH);

  // configuration registers
  logic [IdW-1:0]   id_q [NumChan];
  logic [IdW-1:0]   id_enc_q;
  logic [DistW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q[0]  <= 8'd1;
      id_q[1]  <= 8'd2;
      id_q[2]  <= 8'd3;
      id_q[3]  <= 8'd4;
      id_q[4]  <= 8'd5;
      id_enc_q <= 8'd6;
      thr_q    <= 20'd100000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ID_US_CENTER:     id_q[0]  <= cfg_data_i[IdW-1:0];
        REG_ID_US_SIDE:       id_q[1]  <= cfg_data_i[IdW-1:0];
        REG_ID_IR_SIDE_FRONT: id_q[2]  <= cfg_data_i[IdW-1:0];
        REG_ID_IR_SIDE_BACK:  id_q[3]  <= cfg_data_i[IdW-1:0];
        REG_ID_IR_BACK:       id_q[4]  <= cfg_data_i[IdW-1:0];
        REG_ID_ENCODER:       id_enc_q <= cfg_data_i[IdW-1:0];
        REG_KM_THRESHOLD:     thr_q    <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  assign status_o.frame_start = kind_i;

  // channel decode
  logic [NumChan-1:0] hit;
  logic               hit_enc, ir_hit, ir_ok;
  logic [NumChan-1:0] sel;
  logic               odo_en, unknown_d;
  sample_t            samp;

  always_comb begin
    for (int c = 0; c < NumChan; c++) hit[c] = (sensor_id_i == id_q[c]);
    hit_enc   = (sensor_id_i == id_enc_q);
    ir_hit    = hit[2] || hit[3] || hit[4];
    ir_ok     = (reading_i > 8'd2) || (reading_i == 8'd0);
    sel       = '0;
    odo_en    = 1'b0;
    unknown_d = 1'b0;
    priority if (hit[0] || hit[1]) begin
      sel[0] = hit[0];
      sel[1] = !hit[0];
    end else if (ir_hit && ir_ok) begin
      priority if (hit[2]) sel[2] = 1'b1;
      else if (hit[3])     sel[3] = 1'b1;
      else                 sel[4] = 1'b1;
    end else if (hit_enc) begin
      odo_en = 1'b1;
    end else if (!ir_hit) begin
      unknown_d = 1'b1;
    end
    samp = (reading_i == 8'd0) ? -9'sd1 : sample_t'({1'b0, reading_i});
  end

  // per-channel sorted lists built from insert cells
  sample_t           list_q [NumChan][LIST_DEPTH];
  logic [CW-1:0]     cnt_q  [NumChan];
  logic [NumChan-1:0] full, ins;
  logic              run;

  assign run = cmd_i.accept && !kind_i;

  for (genvar c = 0; c < NumChan; c++) begin : g_ch
    assign full[c] = (cnt_q[c] >= Full);
    assign ins[c]  = run && sel[c] && !full[c];

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic    keep;
      sample_t nxt;
      assign keep = (CW'(i) < cnt_q[c]) && (list_q[c][i] <= samp);
      if (i == 0) begin : g_first
        assign nxt = keep ? list_q[c][i] : samp;
      end else begin : g_rest
        logic prev_le;
        assign prev_le = (CW'(i - 1) < cnt_q[c]) && (list_q[c][i-1] <= samp);
        assign nxt     = keep ? list_q[c][i] : (prev_le ? samp : list_q[c][i-1]);
      end
      always_ff @(posedge clk_i) begin
        if (ins[c]) list_q[c][i] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[c] <= '0;
      end else if (cmd_i.accept && kind_i) begin
        cnt_q[c] <= '0;
      end else if (ins[c]) begin
        cnt_q[c] <= cnt_q[c] + CW'(1);
      end
    end
  end

  // odometer: one add, one compare and subtract, saturate
  logic [DistW-1:0] acc_q;
  logic [KmW-1:0]   km_q;
  logic [DistW:0]   sum, sub;
  logic             roll;

  always_comb begin
    sum  = {1'b0, acc_q} + {{(DistW + 1 - ValW){1'b0}}, reading_i};
    roll = (sum >= {1'b0, thr_q});
    sub  = roll ? (sum - {1'b0, thr_q}) : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      km_q  <= '0;
    end else if (run && odo_en) begin
      acc_q <= sub[DistW] ? AccMax : sub[DistW-1:0];
      if (roll) km_q <= km_q + KmW'(1);
    end
  end

  // flags of the item in flight
  logic unk_q, drop_q;
  always_ff @(posedge clk_i) begin
    if (run) begin
      unk_q  <= unknown_d;
      drop_q <= |(sel & full);
    end
  end

  // result register: upper median of each list
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int c = 0; c < NumChan; c++) begin
        logic [CW-1:0] half;
        half = cnt_q[c] >> 1;
        med_o[c] <= (cnt_q[c] == '0) ? '0 : list_q[c][half[IW-1:0]];
      end
      dist_o    <= acc_q;
      km_o      <= km_q;
      unknown_o <= unk_q;
      dropped_o <= drop_q;
    end
  end

endmodule
`default_nettype wire

// ----- src/multi_channel_batch_median_odometer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_batch_median_odometer
// Frame-based per-channel median filter with wheel odometer.
// ----------------------------------------------------------------------------
// Channels: in_i takes items (kind, sensor_id, reading); out_o delivers one
// result per sensor reading; cfg_i writes the id and threshold registers
// (index 0..6, higher indexes ignored, always ready).
// An item is taken in the cycle of its transfer: the matching list gets the
// value through a row of insert cells and the odometer adds in that edge.
// The median step of the sequencer then loads the upper medians into the
// output register once it is free; a new item is taken only after that
// load; accept and median steps alternate. A frame start gives no result.
// The block accepts the next item while a result waits; if the receiver
// stalls, that next item's result holds in the median step until the
// output register frees, and no further item is taken meanwhile.
// Reset clears list counts, distance and kilometre count and loads the
// register defaults; list contents need no clearing.
// ----------------------------------------------------------------------------
module multi_channel_batch_median_odometer #(
  parameter int LIST_DEPTH = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  mcbmo_in_if.sink    in_i,
  mcbmo_out_if.source out_o,
  mcbmo_cfg_if.sink   cfg_i
);
  import mcbmo_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  sample_t    med [NumChan];

  assign cfg_i.ready = 1'b1;

  mcbmo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mcbmo_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .kind_i      (in_i.kind),
    .sensor_id_i (in_i.sensor_id),
    .reading_i   (in_i.reading),
    .med_o       (med),
    .dist_o      (out_o.distance_in_km),
    .km_o        (out_o.km_count),
    .unknown_o   (out_o.unknown_id),
    .dropped_o   (out_o.dropped_full)
  );

  assign out_o.median_us_center     = med[0];
  assign out_o.median_us_side       = med[1];
  assign out_o.median_ir_side_front = med[2];
  assign out_o.median_ir_side_back  = med[3];
  assign out_o.median_ir_back       = med[4];

endmodule
`default_nettype wire
